FILE: rtl/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared codes, character constants and state type of the modem response
// matcher.
// ----------------------------------------------------------------------------
package mrm_pkg;

    // Action codes carried by an input word.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Status codes carried by a result word.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_OK      = 3'd2;
    localparam logic [2:0] ST_CLOSED  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_MATCH_MODE    = 1'b0;
    localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic        MODE_RESET  = 1'b1;
    localparam logic [15:0] LIMIT_RESET = 16'd15000;

    // Characters of the reply words.
    localparam logic [7:0] CH_R = 8'h72;  // 'r'
    localparam logic [7:0] CH_E = 8'h65;  // 'e'
    localparam logic [7:0] CH_A = 8'h61;  // 'a'
    localparam logic [7:0] CH_D = 8'h64;  // 'd'
    localparam logic [7:0] CH_Y = 8'h79;  // 'y'
    localparam logic [7:0] CH_UO = 8'h4F; // 'O'
    localparam logic [7:0] CH_UK = 8'h4B; // 'K'
    localparam logic [7:0] CH_UC = 8'h43; // 'C'
    localparam logic [7:0] CH_UL = 8'h4C; // 'L'
    localparam logic [7:0] CH_US = 8'h53; // 'S'
    localparam logic [7:0] CH_UE = 8'h45; // 'E'
    localparam logic [7:0] CH_UD = 8'h44; // 'D'

    // Matcher state kept between words.
    typedef struct packed {
        logic        armed;
        logic [2:0]  match_pos;
        logic        closed_branch;
        logic [16:0] elapsed_ticks;
    } t_match_state;

    // Expected letter of "ready" at a given position.
    function automatic logic [7:0] ready_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_R;
            3'd1:    ch = CH_E;
            3'd2:    ch = CH_A;
            3'd3:    ch = CH_D;
            3'd4:    ch = CH_Y;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected letter of the tail of "CLOSED" at positions two to five.
    function automatic logic [7:0] tail_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd2:    ch = CH_UO;
            3'd3:    ch = CH_US;
            3'd4:    ch = CH_UE;
            3'd5:    ch = CH_UD;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/mrm_step.sv
// ----------------------------------------------------------------------------
// mrm_step
// Next-state and status logic for one input word of the matcher.
// ----------------------------------------------------------------------------
module mrm_step
    import mrm_pkg::*;
(
    input  logic [1:0]   i_action,
    input  logic [7:0]   i_byte_value,
    input  logic         i_match_mode,
    input  logic [15:0]  i_timeout_limit,
    input  t_match_state i_state,
    output t_match_state o_state,
    output logic [2:0]   o_status
);

    logic [16:0] ticks_inc;
    logic [2:0]  pos_inc;

    assign ticks_inc = i_state.elapsed_ticks + 17'd1;
    assign pos_inc   = i_state.match_pos + 3'd1;

    always_comb begin
        o_state  = i_state;
        o_status = ST_WAIT;
        if (i_action == ACT_START) begin
            o_state.armed         = 1'b1;
            o_state.match_pos     = 3'd0;
            o_state.closed_branch = 1'b0;
            o_state.elapsed_ticks = 17'd0;
            o_status              = ST_WAIT;
        end else if (!i_state.armed) begin
            o_status = ST_IDLE;
        end else if (i_action == ACT_BYTE) begin
            if (!i_match_mode) begin
                // Waiting for "ready".
                if (i_state.match_pos > 3'd4) begin
                    o_state.match_pos = 3'd0;
                end else if (i_byte_value == ready_char(i_state.match_pos)) begin
                    if (i_state.match_pos == 3'd4) begin
                        o_state.match_pos = 3'd0;
                        o_status          = ST_OK;
                    end else begin
                        o_state.match_pos = pos_inc;
                    end
                end else begin
                    o_state.match_pos = 3'd0;
                end
            end else begin
                // Waiting for "OK" or "CLOSED", each on its own branch.
                if (i_state.match_pos == 3'd0) begin
                    if (i_byte_value == CH_UO) begin
                        o_state.closed_branch = 1'b0;
                        o_state.match_pos     = 3'd1;
                    end else if (i_byte_value == CH_UC) begin
                        o_state.closed_branch = 1'b1;
                        o_state.match_pos     = 3'd1;
                    end
                end else if (i_state.match_pos == 3'd1) begin
                    if (!i_state.closed_branch && i_byte_value == CH_UK) begin
                        o_state.match_pos = 3'd0;
                        o_status          = ST_OK;
                    end else if (i_state.closed_branch && i_byte_value == CH_UL) begin
                        o_state.match_pos = 3'd2;
                    end else begin
                        o_state.match_pos = 3'd0;
                    end
                end else if (i_state.match_pos > 3'd5) begin
                    o_state.match_pos = 3'd0;
                end else if (i_byte_value == tail_char(i_state.match_pos)) begin
                    if (i_state.match_pos == 3'd5) begin
                        o_state.match_pos = 3'd0;
                        o_status          = ST_CLOSED;
                    end else begin
                        o_state.match_pos = pos_inc;
                    end
                end else begin
                    o_state.match_pos = 3'd0;
                end
            end
            if (o_status != ST_WAIT) begin
                o_state.armed = 1'b0;
            end
        end else if (i_action == ACT_TICK) begin
            o_state.elapsed_ticks = ticks_inc;
            if (ticks_inc > {1'b0, i_timeout_limit}) begin
                o_state.armed = 1'b0;
                o_status      = ST_TIMEOUT;
            end
        end
    end

endmodule

FILE: rtl/modem_response_matcher.sv
// ----------------------------------------------------------------------------
// modem_response_matcher
// Watches received modem bytes for a reply word with a millisecond timeout.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+--------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_action, i_byte_value
//  result   | out       | o_out_valid / i_out_stall  | o_status
//  config   | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  A word is taken into an input register, then evaluated combinationally
//  against the matcher state, which writes both the new state and the result
//  register. The result word reaches the output through the input register
//  and then the result register. One word is accepted every cycle unless the
//  result register is full and stalled; the input register is held only then,
//  so throughput is set by the output side.
//  Reset is synchronous and active low; it disarms the matcher and loads the
//  configuration defaults (mode 1, limit 15000).
//
// ----------------------------------------------------------------------------
module modem_response_matcher
    import mrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_byte_value,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    // Configuration port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic         r_match_mode;
    logic [15:0]  r_timeout_limit;

    // Input register.
    logic         r_in_valid;
    logic [1:0]   r_action;
    logic [7:0]   r_byte_value;

    // Matcher state and result register.
    t_match_state r_state;
    t_match_state n_state;
    logic [2:0]   n_status;
    logic         r_out_valid;
    logic [2:0]   r_status;

    logic         out_free;
    logic         eval_fire;
    logic         in_load;

    // The result register can take a new word when it is empty or being read.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign eval_fire  = r_in_valid && out_free;
    assign in_load    = !r_in_valid || eval_fire;

    assign o_in_stall  = !in_load;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    mrm_step u_step (
        .i_action        (r_action),
        .i_byte_value    (r_byte_value),
        .i_match_mode    (r_match_mode),
        .i_timeout_limit (r_timeout_limit),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_status        (n_status)
    );

    // The user must write configuration only while idle; the block does not enforce this and has no interlock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mode    <= MODE_RESET;
            r_timeout_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATCH_MODE:    r_match_mode    <= i_cfg_data[0];
                CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data;
            endcase
        end
    end

    // Input register: loads whenever it is empty or its word moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_action     <= i_action;
            r_byte_value <= i_byte_value;
        end
    end

    // State and result advance together, once per evaluated word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (eval_fire) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/mrm_checker.sv
// ----------------------------------------------------------------------------
// mrm_checker
// Port-level checks of the modem response matcher, bound to the top level.
// ----------------------------------------------------------------------------
module mrm_checker
    import mrm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status
);

    // Only defined status codes ever leave the block.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_TIMEOUT))
        else $error("status code out of range");

    // The input side is held back only when a result is waiting and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result word changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind modem_response_matcher mrm_checker u_mrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status)
);
